### hw/rtl/nlm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlm_pkg: shared types and constants for the nearest location matcher
// Widths, request codes and the structs passed between the scan cells.
// ----------------------------------------------------------------------------
package nlm_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int COORD_BITS  = 24;
    localparam int ID_W        = 31;
    localparam int RAD_W       = 16;
    localparam int DIST_W      = 48;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int SQ_W        = 2 * COORD_BITS;
    localparam int SUM_W       = SQ_W + 1;
    localparam int ENTRY_W     = ID_W + 2 * COORD_BITS + 1;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]                   op;
        logic [ID_W-1:0]              loc_id;
        logic signed [COORD_BITS-1:0] pos_x;
        logic signed [COORD_BITS-1:0] pos_y;
        logic                         zoned;
    } t_in;

    typedef struct packed {
        logic [ID_W-1:0]   new_id;
        logic              kept_same_id;
        logic [DIST_W-1:0] best_distance_sq;
    } t_out;

    typedef struct packed {
        logic [ID_W-1:0]              id;
        logic signed [COORD_BITS-1:0] pos_x;
        logic signed [COORD_BITS-1:0] pos_y;
        logic                         zoned;
    } t_entry;

    typedef struct packed {
        logic [ID_W-1:0]              id;
        logic signed [COORD_BITS-1:0] pos_x;
        logic signed [COORD_BITS-1:0] pos_y;
        logic                         zoned;
        logic [RAD_W-1:0]             radius;
    } t_query;

    // Candidate handed from the distance cell to the best-tracking cell.
    typedef struct packed {
        logic                  valid;
        logic [ID_W-1:0]       id;
        logic                  id_eq;
        logic                  inbox;
        logic                  elig;
        logic [SQ_W-1:0]       sq_x;
        logic [SQ_W-1:0]       sq_y;
    } t_cand;

    typedef struct packed {
        logic              found;
        logic              keep;
        logic [ID_W-1:0]   best_id;
        logic [SUM_W-1:0]  best_d;
    } t_best;

    function automatic logic [DIST_W-1:0] sat_dist(input logic [SUM_W-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return (w > 64'({DIST_W{1'b1}})) ? {DIST_W{1'b1}} : w[DIST_W-1:0];
    endfunction

endpackage

### hw/rtl/nearest_location_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_location_match: nearest-location matcher over a loaded table
// Load and clear requests are handled while idle. A query scans the loaded entries
// one per cycle from the table RAM; its result is registered once the distance and
// best cells have drained, and no new request is accepted until then.
// Scan rate is set by the single RAM read port: one entry per cycle.
// Synchronous active-low reset empties the table and zeroes the radius;
// table contents are not cleared.
// ----------------------------------------------------------------------------
module nearest_location_match (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  nlm_pkg::t_in                 i_in,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output nlm_pkg::t_out                o_out,
    input  logic                        i_cfg_we,
    input  logic [nlm_pkg::RAD_W-1:0]   i_cfg_wdata
);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} t_state;

    t_state                      r_state;
    logic [nlm_pkg::CNT_W-1:0]   r_count;
    logic [nlm_pkg::CNT_W-1:0]   r_addr;
    logic [nlm_pkg::RAD_W-1:0]   r_radius;
    logic                        r_v1;
    logic                        r_start;
    nlm_pkg::t_query             r_query;
    logic                        r_out_valid;
    nlm_pkg::t_out               r_out;

    logic                        in_fire;
    logic                        rd_en;
    logic                        wr_en;
    logic                        busy;
    logic                        out_free;
    nlm_pkg::t_entry             wr_entry;
    logic [nlm_pkg::ENTRY_W-1:0] rd_data;
    nlm_pkg::t_entry             rd_entry;
    nlm_pkg::t_cand              cand;
    nlm_pkg::t_best              best;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign wr_en      = in_fire && (i_in.op == nlm_pkg::OP_LOAD)
                     && (r_count < nlm_pkg::CNT_W'(nlm_pkg::TABLE_DEPTH));
    assign rd_en      = (r_state == S_SCAN) && (r_addr < r_count);
    assign out_free   = !r_out_valid || i_out_ready;

    always_comb begin
        wr_entry.id    = i_in.loc_id;
        wr_entry.pos_x = i_in.pos_x;
        wr_entry.pos_y = i_in.pos_y;
        wr_entry.zoned = i_in.zoned;
    end

    assign rd_entry = nlm_pkg::t_entry'(rd_data);

    nlm_ram #(
        .WIDTH (nlm_pkg::ENTRY_W),
        .DEPTH (nlm_pkg::TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_count[nlm_pkg::ADDR_W-1:0]),
        .i_wdata (wr_entry),
        .i_raddr (r_addr[nlm_pkg::ADDR_W-1:0]),
        .o_rdata (rd_data)
    );

    nlm_dist_cell u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v1),
        .i_entry (rd_entry),
        .i_query (r_query),
        .o_cand  (cand),
        .o_busy  (busy)
    );

    nlm_best_cell u_best (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_cand  (cand),
        .o_best  (best)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_addr      <= '0;
            r_radius    <= '0;
            r_v1        <= 1'b0;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_v1    <= rd_en;
            r_start <= 1'b0;
            if (i_cfg_we) begin
                r_radius <= i_cfg_wdata;
            end
            // In S_DONE the output register is refilled instead of emptied.
            if (r_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        case (i_in.op)
                            nlm_pkg::OP_LOAD: begin
                                if (wr_en) begin
                                    r_count <= r_count + 1'b1;
                                end
                            end
                            nlm_pkg::OP_QUERY: begin
                                r_query.id     <= i_in.loc_id;
                                r_query.pos_x  <= i_in.pos_x;
                                r_query.pos_y  <= i_in.pos_y;
                                r_query.zoned  <= i_in.zoned;
                                r_query.radius <= r_radius;
                                r_addr         <= '0;
                                r_start        <= 1'b1;
                                r_state        <= S_SCAN;
                            end
                            nlm_pkg::OP_CLEAR: begin
                                r_count <= '0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (rd_en) begin
                        r_addr <= r_addr + 1'b1;
                    end else if (!r_v1 && !busy && !r_start) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                        if (best.keep) begin
                            r_out.new_id           <= r_query.id;
                            r_out.kept_same_id     <= 1'b1;
                            r_out.best_distance_sq <= '0;
                        end else begin
                            r_out.new_id           <= best.found ? best.best_id : '0;
                            r_out.kept_same_id     <= 1'b0;
                            r_out.best_distance_sq <= best.found
                                ? nlm_pkg::sat_dist(best.best_d) : '0;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= nlm_pkg::CNT_W'(nlm_pkg::TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_addr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> r_addr <= r_count)
        else $error("scan address ran past the loaded entries");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !r_v1 && !busy)
        else $error("scan chain busy while accepting requests");

    a_kept_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.kept_same_id |-> r_out.best_distance_sq == '0)
        else $error("kept same id with a non-zero distance");

endmodule

### hw/rtl/nlm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlm_ram: generic single-port-write, registered-read RAM
// One write and one read address per cycle; read data is registered and appears in the cycle after the address.
// ----------------------------------------------------------------------------
module nlm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/nlm_dist_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlm_dist_cell: distance cell of the scan chain
// Takes one table entry a cycle, forms absolute offsets and the box test,
// then squares the offsets in a second registered step.
// ----------------------------------------------------------------------------
module nlm_dist_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  nlm_pkg::t_entry i_entry,
    input  nlm_pkg::t_query i_query,
    output nlm_pkg::t_cand  o_cand,
    output logic           o_busy
);

    logic signed [nlm_pkg::COORD_BITS:0] sub_x;
    logic signed [nlm_pkg::COORD_BITS:0] sub_y;
    logic [nlm_pkg::COORD_BITS:0]        neg_x;
    logic [nlm_pkg::COORD_BITS:0]        neg_y;
    logic [nlm_pkg::COORD_BITS-1:0]      abs_x;
    logic [nlm_pkg::COORD_BITS-1:0]      abs_y;

    logic                                r_a_valid;
    logic [nlm_pkg::ID_W-1:0]            r_a_id;
    logic                                r_a_id_eq;
    logic                                r_a_inbox;
    logic                                r_a_elig;
    logic [nlm_pkg::COORD_BITS-1:0]      r_a_dx;
    logic [nlm_pkg::COORD_BITS-1:0]      r_a_dy;
    nlm_pkg::t_cand                      r_cand;

    always_comb begin
        sub_x = {i_entry.pos_x[nlm_pkg::COORD_BITS-1], i_entry.pos_x}
              - {i_query.pos_x[nlm_pkg::COORD_BITS-1], i_query.pos_x};
        sub_y = {i_entry.pos_y[nlm_pkg::COORD_BITS-1], i_entry.pos_y}
              - {i_query.pos_y[nlm_pkg::COORD_BITS-1], i_query.pos_y};
        neg_x = -sub_x;
        neg_y = -sub_y;
        // The magnitude is below 2**COORD_BITS, so it fits in COORD_BITS unsigned bits.
        abs_x = sub_x[nlm_pkg::COORD_BITS] ? neg_x[nlm_pkg::COORD_BITS-1:0]
                                           : sub_x[nlm_pkg::COORD_BITS-1:0];
        abs_y = sub_y[nlm_pkg::COORD_BITS] ? neg_y[nlm_pkg::COORD_BITS-1:0]
                                           : sub_y[nlm_pkg::COORD_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid    <= 1'b0;
            r_cand.valid <= 1'b0;
        end else begin
            r_a_valid    <= i_valid;
            r_cand.valid <= r_a_valid;
        end
        r_a_id    <= i_entry.id;
        r_a_id_eq <= (i_entry.id == i_query.id);
        r_a_inbox <= (32'(abs_x) <= 32'(i_query.radius))
                  && (32'(abs_y) <= 32'(i_query.radius));
        r_a_elig  <= !i_query.zoned || i_entry.zoned;
        r_a_dx    <= abs_x;
        r_a_dy    <= abs_y;

        r_cand.id    <= r_a_id;
        r_cand.id_eq <= r_a_id_eq;
        r_cand.inbox <= r_a_inbox;
        r_cand.elig  <= r_a_elig;
        r_cand.sq_x  <= r_a_dx * r_a_dx;
        r_cand.sq_y  <= r_a_dy * r_a_dy;
    end

    assign o_cand = r_cand;
    assign o_busy = r_a_valid || r_cand.valid;

endmodule

### hw/rtl/nlm_best_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlm_best_cell: best-tracking cell of the scan chain
// Keeps the earliest nearest eligible entry and the same-id box decision.
// ----------------------------------------------------------------------------
module nlm_best_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  nlm_pkg::t_cand  i_cand,
    output nlm_pkg::t_best  o_best
);

    logic [nlm_pkg::SUM_W-1:0] sum;
    logic                      r_seen;
    nlm_pkg::t_best            r_best;

    assign sum = nlm_pkg::SUM_W'(i_cand.sq_x) + nlm_pkg::SUM_W'(i_cand.sq_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_start) begin
            r_seen       <= 1'b0;
            r_best.found <= 1'b0;
            r_best.keep  <= 1'b0;
        end else if (i_cand.valid) begin
            // Only the first entry carrying the query id decides the box test.
            if (i_cand.id_eq && !r_seen) begin
                r_seen      <= 1'b1;
                r_best.keep <= i_cand.inbox;
            end
            if (i_cand.elig && (!r_best.found || sum < r_best.best_d)) begin
                r_best.found   <= 1'b1;
                r_best.best_id <= i_cand.id;
                r_best.best_d  <= sum;
            end
        end
    end

    assign o_best = r_best;

endmodule
